FILE: hdl/kc_pkg.sv
package kc_pkg;

    localparam int DATA_WIDTH_DEFAULT = 32;
    localparam int RESULT_WIDTH       = 32;

    // Key codes carried in the operation field
    localparam logic [2:0] OP_DIGIT = 3'd0;
    localparam logic [2:0] OP_ADD   = 3'd1;
    localparam logic [2:0] OP_SUB   = 3'd2;
    localparam logic [2:0] OP_MUL   = 3'd3;
    localparam logic [2:0] OP_DIV   = 3'd4;
    localparam logic [2:0] OP_ENTER = 3'd5;
    localparam logic [2:0] OP_NONE  = 3'd0;

    localparam logic [3:0] DIGIT_MAX = 4'd9;

    typedef struct packed {
        logic [2:0] operation;
        logic [3:0] digit;
    } kc_in_t;

    typedef struct packed {
        logic signed [RESULT_WIDTH-1:0] result;
        logic                           is_positive;
    } kc_out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_EMIT
    } kc_state_t;

    typedef enum logic [1:0] {
        ALU_IDLE,
        ALU_MUL,
        ALU_DIV,
        ALU_FIX
    } kc_alu_state_t;

    typedef struct packed {
        logic       start;
        logic [2:0] op;
        logic       zero_div_as_one;
    } kc_alu_req_t;

endpackage

FILE: hdl/kc_alu.sv
module kc_alu #(
    parameter int DATA_WIDTH = kc_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  kc_pkg::kc_alu_req_t   req,
    input  logic [DATA_WIDTH-1:0] a,
    input  logic [DATA_WIDTH-1:0] b,
    output logic                  done,
    output logic [DATA_WIDTH-1:0] result
);

    localparam int CNT_W = $clog2(DATA_WIDTH);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_WIDTH - 1);

    kc_pkg::kc_alu_state_t state_reg, state_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DATA_WIDTH-1:0] acc_reg, acc_next;     // product, remainder
    logic [DATA_WIDTH-1:0] opa_reg, opa_next;     // multiplicand, dividend/quotient
    logic [DATA_WIDTH-1:0] opb_reg, opb_next;     // multiplier, divisor
    logic                  neg_reg, neg_next;
    logic [DATA_WIDTH-1:0] res_reg, res_next;

    logic [DATA_WIDTH-1:0] mag_a, mag_b;
    logic [DATA_WIDTH:0]   rem_shift, rem_diff;

    assign mag_a = a[DATA_WIDTH-1] ? (DATA_WIDTH'(0) - a) : a;
    assign mag_b = b[DATA_WIDTH-1] ? (DATA_WIDTH'(0) - b) : b;

    // One restoring step: shift in the next dividend bit, try the subtract
    assign rem_shift = {acc_reg, opa_reg[DATA_WIDTH-1]};
    assign rem_diff  = rem_shift - {1'b0, opb_reg};

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        opa_next   = opa_reg;
        opb_next   = opb_reg;
        neg_next   = neg_reg;
        res_next   = res_reg;
        unique case (state_reg)
            kc_pkg::ALU_IDLE:
            begin
                if (req.start)
                begin
                    cnt_next = '0;
                    acc_next = '0;
                    case (req.op)
                        kc_pkg::OP_ADD:
                        begin
                            res_next  = a + b;
                            done_next = 1'b1;
                        end
                        kc_pkg::OP_SUB:
                        begin
                            res_next  = a - b;
                            done_next = 1'b1;
                        end
                        kc_pkg::OP_MUL:
                        begin
                            opa_next   = a;
                            opb_next   = b;
                            state_next = kc_pkg::ALU_MUL;
                        end
                        kc_pkg::OP_DIV:
                        begin
                            if (b == '0)
                            begin
                                res_next  = req.zero_div_as_one ? a : '0;
                                done_next = 1'b1;
                            end
                            else
                            begin
                                opa_next   = mag_a;
                                opb_next   = mag_b;
                                neg_next   = a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1];
                                state_next = kc_pkg::ALU_DIV;
                            end
                        end
                        default:
                        begin
                            res_next  = a;
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            kc_pkg::ALU_MUL:
            begin
                if (opb_reg[0])
                    acc_next = acc_reg + opa_reg;
                opa_next = {opa_reg[DATA_WIDTH-2:0], 1'b0};
                opb_next = {1'b0, opb_reg[DATA_WIDTH-1:1]};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    res_next   = (opb_reg[0]) ? (acc_reg + opa_reg) : acc_reg;
                    done_next  = 1'b1;
                    state_next = kc_pkg::ALU_IDLE;
                end
            end
            kc_pkg::ALU_DIV:
            begin
                if (!rem_diff[DATA_WIDTH])
                    acc_next = rem_diff[DATA_WIDTH-1:0];
                else
                    acc_next = rem_shift[DATA_WIDTH-1:0];
                opa_next = {opa_reg[DATA_WIDTH-2:0], ~rem_diff[DATA_WIDTH]};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                    state_next = kc_pkg::ALU_FIX;
            end
            kc_pkg::ALU_FIX:
            begin
                // apply the quotient sign
                res_next   = neg_reg ? (DATA_WIDTH'(0) - opa_reg) : opa_reg;
                done_next  = 1'b1;
                state_next = kc_pkg::ALU_IDLE;
            end
            default:
            begin
                state_next = kc_pkg::ALU_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= kc_pkg::ALU_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        opa_reg <= opa_next;
        opb_reg <= opb_next;
        neg_reg <= neg_next;
        res_reg <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

    a_done_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> state_reg == kc_pkg::ALU_IDLE)
        else $error("alu done outside idle");

    a_mul_finishes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == kc_pkg::ALU_MUL && cnt_reg == CNT_LAST) |=> done_reg)
        else $error("multiply did not finish after last step");

    a_div_to_fix: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == kc_pkg::ALU_DIV && cnt_reg == CNT_LAST)
            |=> state_reg == kc_pkg::ALU_FIX)
        else $error("divide did not reach sign fix");

    a_start_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (req.start && state_reg != kc_pkg::ALU_IDLE) |-> 1'b0)
        else $error("alu started while busy");

endmodule

FILE: hdl/keypad_calculator_core.sv
// Keypad calculator core. Each key is one input transaction: digits append to the
// active operand, an operator key folds any pending operation into the first
// operand, and enter with an operator pending emits one result transaction and
// clears the state. Digit keys, operator keys with nothing pending and ignored
// codes are handled in the idle state. Folding or entering runs through a shared
// arithmetic unit: add and subtract are computed directly, multiply takes one
// multiplier bit per cycle, divide one quotient bit per cycle and then the sign
// fix, and enter then loads the output register. The core takes one key at a
// time; a finished result waits in the output register while new keys are
// accepted, and an enter that finishes while that register is still full holds
// until it drains.
module keypad_calculator_core #(
    parameter int DATA_WIDTH = kc_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  kc_pkg::kc_in_t  in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output kc_pkg::kc_out_t out_data
);

    kc_pkg::kc_state_t     state_reg, state_next;
    logic [DATA_WIDTH-1:0] first_reg, first_next;
    logic [DATA_WIDTH-1:0] second_reg, second_next;
    logic [2:0]            pending_reg, pending_next;
    logic [2:0]            new_op_reg, new_op_next;
    logic                  enter_reg, enter_next;
    logic                  out_valid_reg, out_valid_next;
    kc_pkg::kc_out_t       out_reg, out_next;

    kc_pkg::kc_alu_req_t   alu_req;
    logic                  alu_done;
    logic [DATA_WIDTH-1:0] alu_result;

    logic                            accept;
    logic                            out_load;
    logic                            is_digit, is_oper, is_enter;
    logic [DATA_WIDTH-1:0]           operand_sel, appended;
    logic [kc_pkg::RESULT_WIDTH-1:0] result_ext;

    kc_alu #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (alu_req),
        .a      (first_reg),
        .b      (second_reg),
        .done   (alu_done),
        .result (alu_result)
    );

    generate
        if (DATA_WIDTH >= kc_pkg::RESULT_WIDTH)
        begin : g_trunc
            assign result_ext = alu_result[kc_pkg::RESULT_WIDTH-1:0];
        end
        else
        begin : g_sext
            assign result_ext = {{(kc_pkg::RESULT_WIDTH-DATA_WIDTH){alu_result[DATA_WIDTH-1]}},
                                 alu_result};
        end
    endgenerate

    assign accept   = in_valid && in_ready;
    assign is_digit = (in_data.operation == kc_pkg::OP_DIGIT) &&
                      (in_data.digit <= kc_pkg::DIGIT_MAX);
    assign is_oper  = (in_data.operation == kc_pkg::OP_ADD) ||
                      (in_data.operation == kc_pkg::OP_SUB) ||
                      (in_data.operation == kc_pkg::OP_MUL) ||
                      (in_data.operation == kc_pkg::OP_DIV);
    assign is_enter = (in_data.operation == kc_pkg::OP_ENTER);

    // value * 10 + digit as two shifts and two adds
    assign operand_sel = (pending_reg != kc_pkg::OP_NONE) ? second_reg : first_reg;
    assign appended    = {operand_sel[DATA_WIDTH-4:0], 3'b000}
                       + {operand_sel[DATA_WIDTH-2:0], 1'b0}
                       + {{(DATA_WIDTH-4){1'b0}}, in_data.digit};

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            kc_pkg::ST_IDLE:
            begin
                if (in_valid && (is_oper || is_enter) && (pending_reg != kc_pkg::OP_NONE))
                    state_next = kc_pkg::ST_CALC;
            end
            kc_pkg::ST_CALC:
            begin
                if (alu_done)
                    state_next = enter_reg ? kc_pkg::ST_EMIT : kc_pkg::ST_IDLE;
            end
            kc_pkg::ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = kc_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = kc_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs and datapath updates
    always_comb
    begin
        in_ready                = 1'b0;
        out_load                = 1'b0;
        alu_req.start           = 1'b0;
        alu_req.op              = pending_reg;
        alu_req.zero_div_as_one = !is_enter;
        first_next              = first_reg;
        second_next             = second_reg;
        pending_next            = pending_reg;
        new_op_next             = new_op_reg;
        enter_next              = enter_reg;
        unique case (state_reg)
            kc_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (accept)
                begin
                    if (is_digit)
                    begin
                        if (pending_reg != kc_pkg::OP_NONE)
                            second_next = appended;
                        else
                            first_next = appended;
                    end
                    else if (is_oper || is_enter)
                    begin
                        if (pending_reg != kc_pkg::OP_NONE)
                        begin
                            alu_req.start = 1'b1;
                            new_op_next   = in_data.operation;
                            enter_next    = is_enter;
                        end
                        else if (is_oper)
                        begin
                            pending_next = in_data.operation;
                        end
                    end
                end
            end
            kc_pkg::ST_CALC:
            begin
                if (alu_done && !enter_reg)
                begin
                    first_next   = alu_result;
                    second_next  = '0;
                    pending_next = new_op_reg;
                end
            end
            kc_pkg::ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load     = 1'b1;
                    first_next   = '0;
                    second_next  = '0;
                    pending_next = kc_pkg::OP_NONE;
                end
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (out_load)
        begin
            out_valid_next       = 1'b1;
            out_next.result      = result_ext;
            out_next.is_positive = !alu_result[DATA_WIDTH-1] && (alu_result != '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kc_pkg::ST_IDLE;
            first_reg     <= '0;
            second_reg    <= '0;
            pending_reg   <= kc_pkg::OP_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            first_reg     <= first_next;
            second_reg    <= second_next;
            pending_reg   <= pending_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        new_op_reg <= new_op_next;
        enter_reg  <= enter_next;
        out_reg    <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_load_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == kc_pkg::ST_EMIT)
        else $error("result appeared without an emit");

    a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (pending_reg == kc_pkg::OP_NONE && first_reg == '0 && second_reg == '0))
        else $error("state not cleared after enter");

    a_calc_has_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == kc_pkg::ST_CALC) |-> (pending_reg != kc_pkg::OP_NONE))
        else $error("calculation without pending operator");

    a_fold_sets_op: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == kc_pkg::ST_CALC && alu_done && !enter_reg)
            |=> (second_reg == '0 && pending_reg != kc_pkg::OP_NONE))
        else $error("fold did not update operands");

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam logic [2:0] OP_SPARE_LO = 3'd6;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;
    localparam logic [3:0] DIGIT_BAD   = 4'hF;

    localparam bit [63:0] VALUE_MAX_POS  = 64'd2147483647;
    localparam bit [63:0] VALUE_MOST_NEG = 64'd2147483648;
    localparam bit [63:0] VALUE_MINUS1   = 64'd4294967295;

    localparam int TARGET_KEYS   = 1100;
    localparam int CALM_AFTER    = 950;
    localparam int HOLD_AT       = 400;
    localparam int DRAIN_AT      = 700;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 60;
    localparam int QUIET_LIMIT   = 3000;

    class calc_scoreboard;
        bit [31:0]       first_op;
        bit [31:0]       second_op;
        logic [2:0]      pending_op;
        kc_pkg::kc_out_t pending_results[$];
        int              errors;

        function new();
            first_op   = '0;
            second_op  = '0;
            pending_op = kc_pkg::OP_NONE;
            errors     = 0;
        endfunction

        // Signed divide, truncating toward zero; divisor must be nonzero
        function bit [31:0] quotient(bit [31:0] a, bit [31:0] b);
            bit [31:0] mag_a;
            bit [31:0] mag_b;
            bit [31:0] q;
            mag_a = a[31] ? -a : a;
            mag_b = b[31] ? -b : b;
            q = mag_a / mag_b;
            if (a[31] != b[31])
                q = -q;
            return q;
        endfunction

        function bit [31:0] apply_operator(logic [2:0] op, bit [31:0] a, bit [31:0] b,
                                           bit zero_div_as_one);
            case (op)
                kc_pkg::OP_ADD: return a + b;
                kc_pkg::OP_SUB: return a - b;
                kc_pkg::OP_MUL: return a * b;
                kc_pkg::OP_DIV:
                begin
                    if (b == 0)
                        return zero_div_as_one ? a : 32'd0;
                    return quotient(a, b);
                end
                default: return a;
            endcase
        endfunction

        function void note_key(kc_pkg::kc_in_t k);
            bit [31:0]       r;
            kc_pkg::kc_out_t exp_out;
            if (k.operation == kc_pkg::OP_DIGIT)
            begin
                if (k.digit > kc_pkg::DIGIT_MAX)
                    return;
                if (pending_op != kc_pkg::OP_NONE)
                    second_op = second_op * 10 + k.digit;
                else
                    first_op = first_op * 10 + k.digit;
            end
            else if (k.operation >= kc_pkg::OP_ADD && k.operation <= kc_pkg::OP_DIV)
            begin
                if (pending_op != kc_pkg::OP_NONE)
                begin
                    first_op  = apply_operator(pending_op, first_op, second_op, 1'b1);
                    second_op = '0;
                end
                pending_op = k.operation;
            end
            else if (k.operation == kc_pkg::OP_ENTER && pending_op != kc_pkg::OP_NONE)
            begin
                r = apply_operator(pending_op, first_op, second_op, 1'b0);
                exp_out.result      = r;
                exp_out.is_positive = !r[31] && (r != 0);
                pending_results.push_back(exp_out);
                first_op   = '0;
                second_op  = '0;
                pending_op = kc_pkg::OP_NONE;
            end
        endfunction

        function void check_result(kc_pkg::kc_out_t got);
            kc_pkg::kc_out_t exp_out;
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result: expected none, actual %0d", $time,
                         got.result);
                return;
            end
            exp_out = pending_results.pop_front();
            if (got.result !== exp_out.result)
            begin
                errors++;
                $display("%0t: result mismatch: expected %0d, actual %0d", $time,
                         exp_out.result, got.result);
            end
            if (got.is_positive !== exp_out.is_positive)
            begin
                errors++;
                $display("%0t: is_positive mismatch: expected %0b, actual %0b", $time,
                         exp_out.is_positive, got.is_positive);
            end
        endfunction
    endclass

    logic            clk = 1'b0;
    logic            rst_n;
    logic            in_valid;
    logic            in_ready;
    kc_pkg::kc_in_t  in_data;
    logic            out_valid;
    logic            out_ready;
    kc_pkg::kc_out_t out_data;

    calc_scoreboard board = new();
    int keys_sent;
    int quiet_cycles = 0;
    bit calm;
    bit hold_req;
    bit hold_done;
    bit drain_done;

    keypad_calculator_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic send_key(input logic [2:0] op, input logic [3:0] dig);
        kc_pkg::kc_in_t k;
        k.operation = op;
        k.digit     = dig;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= k;
        do @(posedge clk); while (in_ready !== 1'b1);
        board.note_key(k);
        if (op <= kc_pkg::OP_ENTER && !(op == kc_pkg::OP_DIGIT && dig > kc_pkg::DIGIT_MAX))
            keys_sent++;
        if (keys_sent >= CALM_AFTER)
            calm = 1'b1;
    endtask

    // Key in a value in decimal, most significant digit first; a zero is sometimes left out
    task automatic send_number(input bit [63:0] value);
        bit [3:0] digs[20];
        int       count;
        if (value == 0 && $urandom_range(0, 2) == 0)
            return;
        count = 0;
        do
        begin
            digs[count] = 4'(value % 10);
            value = value / 10;
            count++;
        end
        while (value != 0);
        for (int i = count - 1; i >= 0; i--)
            send_key(kc_pkg::OP_DIGIT, digs[i]);
    endtask

    function automatic bit [63:0] pick_operand();
        case ($urandom_range(0, 11))
            0: return 64'd0;
            1: return 64'd1;
            2: return VALUE_MAX_POS;
            3: return VALUE_MOST_NEG;
            4: return VALUE_MINUS1;
            5: return {$urandom, $urandom} % 64'd1000000000000;
            6, 7: return 64'($urandom);
            default: return 64'($urandom_range(0, 999));
        endcase
    endfunction

    task automatic send_expression();
        logic [2:0] op;
        send_number(pick_operand());
        repeat ($urandom_range(1, 3))
        begin
            op = 3'(kc_pkg::OP_ADD + $urandom_range(0, 3));
            send_key(op, 4'($urandom_range(0, 15)));
            send_number(pick_operand());
        end
        // leave an occasional chain open so the next keys land mid-expression
        if ($urandom_range(0, 9) != 0)
            send_key(kc_pkg::OP_ENTER, 4'($urandom_range(0, 15)));
    endtask

    task automatic wait_results_drained();
        while (board.pending_results.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        bit hold_taken;
        hold_taken = 1'b0;
        out_ready  = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_result(out_data);
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        int kind;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        keys_sent  = 0;
        calm       = 1'b0;
        hold_req   = 1'b0;
        hold_done  = 1'b0;
        drain_done = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // enter with nothing pending, spare codes, out-of-range digit
        send_key(kc_pkg::OP_ENTER, DIGIT_BAD);
        send_key(OP_SPARE_LO, 4'd0);
        send_key(OP_SPARE_HI, DIGIT_BAD);
        send_key(kc_pkg::OP_DIGIT, DIGIT_BAD);
        // 90 + 7 - 8 * 3 / 0 (fold keeps 267) then enter on divide by zero
        send_key(kc_pkg::OP_DIGIT, kc_pkg::DIGIT_MAX);
        send_key(kc_pkg::OP_DIGIT, 4'd0);
        send_key(kc_pkg::OP_ADD, 4'd0);
        send_key(kc_pkg::OP_DIGIT, 4'd7);
        send_key(kc_pkg::OP_SUB, 4'd0);
        send_key(kc_pkg::OP_DIGIT, 4'd8);
        send_key(kc_pkg::OP_MUL, 4'd0);
        send_key(kc_pkg::OP_DIGIT, 4'd3);
        send_key(kc_pkg::OP_DIV, 4'd0);
        send_key(kc_pkg::OP_DIV, 4'd0);
        send_key(kc_pkg::OP_ENTER, 4'd0);
        // negative, zero and positive results
        send_key(kc_pkg::OP_DIGIT, 4'd5);
        send_key(kc_pkg::OP_SUB, 4'd0);
        send_key(kc_pkg::OP_DIGIT, 4'd9);
        send_key(kc_pkg::OP_ENTER, 4'd0);
        send_key(kc_pkg::OP_DIGIT, 4'd4);
        send_key(kc_pkg::OP_MUL, 4'd0);
        send_key(kc_pkg::OP_ENTER, 4'd0);
        send_key(kc_pkg::OP_DIGIT, 4'd6);
        send_key(kc_pkg::OP_ADD, 4'd0);
        send_key(kc_pkg::OP_DIGIT, 4'd1);
        send_key(kc_pkg::OP_ENTER, 4'd0);

        while (keys_sent < TARGET_KEYS)
        begin
            if (!hold_done && keys_sent >= HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_req  = 1'b1;
            end
            if (!drain_done && keys_sent >= DRAIN_AT)
            begin
                drain_done = 1'b1;
                in_valid <= 1'b0;
                wait_results_drained();
            end
            kind = int'($urandom_range(0, 19));
            if (kind == 0)
            begin
                // most negative divided by minus one
                send_number(VALUE_MOST_NEG);
                send_key(kc_pkg::OP_DIV, 4'($urandom_range(0, 15)));
                send_number(VALUE_MINUS1);
                send_key(kc_pkg::OP_ENTER, 4'($urandom_range(0, 15)));
            end
            else if (kind <= 2)
            begin
                repeat ($urandom_range(1, 4))
                    send_key(3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)));
            end
            else
            begin
                send_expression();
            end
        end

        in_valid <= 1'b0;
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (board.errors == 0 && board.pending_results.size() == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("%0t: %0d errors, %0d results still expected", $time, board.errors,
                     board.pending_results.size());
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
